[design/lsmh_pkg.sv]
// Package for the limit switch homing sequencer: field widths, phase codes,
// register map and the per-motor default home offsets. No dependencies.
package lsmh_pkg;

  localparam int MOTORS      = 8;
  localparam int MOTOR_W     = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int IDX_W       = 3;   // motor_index field width
  localparam int USE_W       = 4;   // motors_in_use register width
  localparam int TICK_W      = 32;
  localparam int STEP_W      = 16;
  localparam int TOL_W       = 16;
  localparam int PROD_W      = STEP_W + TICK_W;
  localparam int PADDR_W     = 4;

  // Per-motor homing phase, one-hot.
  typedef enum logic [3:0] {
    PH_RETRACT = 4'b0001,
    PH_ADVANCE = 4'b0010,
    PH_HOMING  = 4'b0100,
    PH_HOMED   = 4'b1000
  } phase_t;

  // Phase codes as reported on the result channel.
  localparam logic [1:0] PC_RETRACT = 2'd0;
  localparam logic [1:0] PC_ADVANCE = 2'd1;
  localparam logic [1:0] PC_HOMING  = 2'd2;
  localparam logic [1:0] PC_HOMED   = 2'd3;

  // Register indexes (paddr[3:2]).
  localparam logic [1:0] REG_ADVANCE_STEP     = 2'd0;
  localparam logic [1:0] REG_SETTLE_TOLERANCE = 2'd1;
  localparam logic [1:0] REG_MOTORS_IN_USE    = 2'd2;

  localparam logic [STEP_W-1:0] ADVANCE_STEP_RST     = 16'd256;
  localparam logic [TOL_W-1:0]  SETTLE_TOLERANCE_RST = 16'd10;
  localparam logic [USE_W-1:0]  MOTORS_IN_USE_RST    = 4'd8;

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] c;
    case (ph)
      PH_RETRACT: c = PC_RETRACT;
      PH_ADVANCE: c = PC_ADVANCE;
      PH_HOMING:  c = PC_HOMING;
      PH_HOMED:   c = PC_HOMED;
      default:    c = PC_RETRACT;
    endcase
    return c;
  endfunction

  // Home angles pi/8, pi/32, pi/8, pi/32, pi/8, pi/6, -pi/16, 0 at 4*256*66 ticks/turn.
  function automatic logic signed [TICK_W-1:0] default_offset(input logic [MOTOR_W-1:0] idx);
    logic signed [TICK_W-1:0] v;
    case (idx)
      3'd0:    v = 32'sd4224;
      3'd1:    v = 32'sd1056;
      3'd2:    v = 32'sd4224;
      3'd3:    v = 32'sd1056;
      3'd4:    v = 32'sd4224;
      3'd5:    v = 32'sd5632;
      3'd6:    v = -32'sd2112;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

[design/lsmh_if.sv]
// Request channels of the homing sequencer: motor samples in, setpoints out.
// Depends on lsmh_pkg for field widths.
interface lsmh_in_if import lsmh_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         motor_index;
  logic                     switch_released;
  logic signed [TICK_W-1:0] encoder_ticks;
  logic                     end_of_cycle;

  modport source(output valid, motor_index, switch_released, encoder_ticks, end_of_cycle,
                 input ready);
  modport sink(input valid, motor_index, switch_released, encoder_ticks, end_of_cycle,
               output ready);
endinterface

interface lsmh_out_if import lsmh_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_motor_index;
  logic signed [TICK_W-1:0] setpoint_ticks;
  logic                     setpoint_valid;
  logic [1:0]               motor_phase_out;
  logic                     all_homed;

  modport source(output valid, out_motor_index, setpoint_ticks, setpoint_valid,
                 motor_phase_out, all_homed, input ready);
  modport sink(input valid, out_motor_index, setpoint_ticks, setpoint_valid,
               motor_phase_out, all_homed, output ready);
endinterface

[design/limit_switch_motor_homing.sv]
// Homing sequencer top level. A request passes an input register, then a result register,
// before its result is valid. Throughput: one request per cycle while the result channel
// is not stalled; the per-motor state is read and written in the same cycle as the 16x32
// ramp multiply, so back-to-back samples of one motor chain.
// Reset (rst_n low, synchronous): phases retract, offsets to the default table,
// cycle counter and advance starts zero, registers to their reset values.
// Depends on lsmh_pkg and the channel interfaces in lsmh_if.sv.
module limit_switch_motor_homing import lsmh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  lsmh_in_if.sink              in_if,
  lsmh_out_if.source           out_if,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // Configuration registers
  logic [STEP_W-1:0] advance_step_r;
  logic [TOL_W-1:0]  settle_tolerance_r;
  logic [USE_W-1:0]  motors_in_use_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      advance_step_r     <= ADVANCE_STEP_RST;
      settle_tolerance_r <= SETTLE_TOLERANCE_RST;
      motors_in_use_r    <= MOTORS_IN_USE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ADVANCE_STEP:     advance_step_r     <= pwdata[STEP_W-1:0];
        REG_SETTLE_TOLERANCE: settle_tolerance_r <= pwdata[TOL_W-1:0];
        REG_MOTORS_IN_USE:    motors_in_use_r    <= pwdata[USE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ADVANCE_STEP:     prdata = {{(32-STEP_W){1'b0}}, advance_step_r};
      REG_SETTLE_TOLERANCE: prdata = {{(32-TOL_W){1'b0}}, settle_tolerance_r};
      REG_MOTORS_IN_USE:    prdata = {{(32-USE_W){1'b0}}, motors_in_use_r};
      default:              prdata = 32'd0;
    endcase
  end

  // Input stage
  logic                     s1_valid_r;
  logic [IDX_W-1:0]         s1_idx_r;
  logic                     s1_rel_r;
  logic signed [TICK_W-1:0] s1_enc_r;
  logic                     s1_eoc_r;
  logic                     s1_go;
  logic                     out_valid_r;

  assign s1_go       = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_idx_r <= in_if.motor_index;
      s1_rel_r <= in_if.switch_released;
      s1_enc_r <= in_if.encoder_ticks;
      s1_eoc_r <= in_if.end_of_cycle;
    end
  end

  // Per-motor state
  phase_t                   phase_r  [MOTORS];
  logic signed [TICK_W-1:0] offset_r [MOTORS];
  logic [TICK_W-1:0]        start_r  [MOTORS];
  logic [TICK_W-1:0]        cycle_count_r;

  // Single-pass evaluation
  logic [MOTOR_W-1:0]       k;
  logic [USE_W-1:0]         used;
  logic                     in_use;
  logic                     first_cycle;
  phase_t                   ph_cur;
  phase_t                   ph_new;
  logic signed [TICK_W-1:0] off_cur;
  logic signed [TICK_W-1:0] off_new;
  logic [TICK_W-1:0]        start_new;
  logic [TICK_W-1:0]        ramp_n;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-9:0]        mag;
  logic                     mag_big;
  logic signed [TICK_W-1:0] ramp_pos;
  logic signed [TICK_W-1:0] ramp_neg;
  logic signed [TICK_W:0]   cap_sum;
  logic signed [TICK_W:0]   diff;
  logic [TICK_W:0]          diff_abs;
  logic signed [TICK_W-1:0] sp;
  logic                     sp_valid;
  logic                     wr_state;
  logic                     all_homed;

  always_comb begin
    used = motors_in_use_r;
    if (used < USE_W'(1))      used = USE_W'(1);
    if (used > USE_W'(MOTORS)) used = USE_W'(MOTORS);
  end

  assign k           = s1_idx_r[MOTOR_W-1:0];
  assign in_use      = USE_W'(s1_idx_r) < used;
  assign first_cycle = cycle_count_r == '0;
  assign ph_cur      = phase_r[k];
  assign off_cur     = offset_r[k];

  // Ramp magnitude floor(step*n/256), clamped to 2^31-1 (-2^31 when negated)
  assign ramp_n   = (ph_cur == PH_RETRACT) ? cycle_count_r : cycle_count_r - start_r[k];
  assign prod     = PROD_W'(advance_step_r) * PROD_W'(ramp_n);
  assign mag      = prod[PROD_W-1:8];
  assign mag_big  = |mag[PROD_W-9:TICK_W-1];
  assign ramp_pos = mag_big ? 32'sh7FFF_FFFF : $signed(mag[TICK_W-1:0]);
  assign ramp_neg = mag_big ? 32'sh8000_0000 : -$signed(mag[TICK_W-1:0]);

  assign cap_sum  = 33'(s1_enc_r) + 33'(off_cur);
  assign diff     = 33'(s1_enc_r) - 33'(off_cur);
  assign diff_abs = diff[TICK_W] ? 33'(-diff) : 33'(diff);

  always_comb begin
    ph_new    = ph_cur;
    off_new   = off_cur;
    start_new = start_r[k];
    sp        = '0;
    sp_valid  = 1'b0;
    if (first_cycle) begin
      ph_new = s1_rel_r ? PH_ADVANCE : PH_RETRACT;
    end else begin
      sp_valid = 1'b1;
      case (ph_cur)
        PH_RETRACT: begin
          sp = ramp_neg;
          if (s1_rel_r) begin
            ph_new    = PH_ADVANCE;
            start_new = cycle_count_r;
          end
        end
        PH_ADVANCE: begin
          sp = ramp_pos;
          if (!s1_rel_r) begin
            ph_new = PH_HOMING;
            if (cap_sum > 33'sh0_7FFF_FFFF)       off_new = 32'sh7FFF_FFFF;
            else if (cap_sum < -33'sh0_8000_0000) off_new = 32'sh8000_0000;
            else                                  off_new = cap_sum[TICK_W-1:0];
          end
        end
        PH_HOMING: begin
          sp = off_cur;
          if (diff_abs < 33'(settle_tolerance_r)) ph_new = PH_HOMED;
        end
        default: sp = off_cur;
      endcase
    end
    if (!in_use) begin
      sp       = '0;
      sp_valid = 1'b0;
    end
  end

  assign wr_state = s1_go && in_use;

  // Completion flag reflects this request's own update
  always_comb begin
    all_homed = 1'b1;
    for (int i = 0; i < MOTORS; i++) begin
      if (USE_W'(i) < used) begin
        if (in_use && k == MOTOR_W'(i)) begin
          if (ph_new != PH_HOMED) all_homed = 1'b0;
        end else if (phase_r[i] != PH_HOMED) begin
          all_homed = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_count_r <= '0;
      for (int i = 0; i < MOTORS; i++) begin
        phase_r[i]  <= PH_RETRACT;
        offset_r[i] <= default_offset(MOTOR_W'(i));
        start_r[i]  <= '0;
      end
    end else begin
      if (s1_go && s1_eoc_r) cycle_count_r <= cycle_count_r + 1'b1;
      if (wr_state) begin
        phase_r[k]  <= ph_new;
        offset_r[k] <= off_new;
        start_r[k]  <= start_new;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_if.out_motor_index <= s1_idx_r;
      out_if.setpoint_ticks  <= sp;
      out_if.setpoint_valid  <= sp_valid;
      out_if.motor_phase_out <= phase_code(in_use ? ph_new : ph_cur);
      out_if.all_homed       <= all_homed;
    end
  end

  assign out_if.valid = out_valid_r;

`ifndef SYNTHESIS
  a_no_setpoint_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.setpoint_valid |-> out_if.setpoint_ticks == '0)
    else $error("setpoint not zero while not commanded");

  a_cycle_step: assert property (@(posedge clk) disable iff (!rst_n)
    cycle_count_r != $past(cycle_count_r) |->
      cycle_count_r == $past(cycle_count_r) + 1'b1 && $past(s1_go) && $past(s1_eoc_r))
    else $error("cycle counter moved without an end-of-cycle request");

  a_homed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && in_use && !first_cycle && ph_cur == PH_HOMED |=> phase_r[$past(k)] == PH_HOMED)
    else $error("homed motor left the homed phase");

  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |=> s1_valid_r && $stable(s1_idx_r) && $stable(s1_enc_r))
    else $error("stalled input stage was overwritten");
`endif

endmodule
